### design/nsi_pkg.sv
package nsi_pkg;

    // grid and angle
    localparam int MAX_DIM     = 256;
    localparam int IDX_W       = 8;
    localparam int SIZE_W      = 9;
    localparam int PHASE_W     = 32;
    localparam int ANG_STEPS   = IDX_W + PHASE_W;
    localparam int ANG_PER_STG = 8;
    localparam int ANG_STGS    = ANG_STEPS / ANG_PER_STG;

    // rotation cordic in q30, residual angle in units of 2^-32 turn
    localparam int CORDIC_STEPS   = 24;
    localparam int CORDIC_PER_STG = 4;
    localparam int CORDIC_STGS    = CORDIC_STEPS / CORDIC_PER_STG;
    localparam int CXW            = 34;
    localparam int CZW            = 33;
    localparam logic signed [CXW-1:0] CORDIC_X0 = 34'sd652032874;
    localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // quadrant codes of the phase
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // inverse stage
    localparam int N_ENT     = 6;
    localparam int OUT_W     = 32;
    localparam int DIV_STEPS = OUT_W;
    localparam int DMAG_W    = 96;
    localparam int HMAG_W    = 64;

    // configuration register indexes
    typedef logic [2:0] t_reg_addr;
    localparam t_reg_addr REG_LAMBDA = 3'd0;
    localparam t_reg_addr REG_MU     = 3'd1;
    localparam t_reg_addr REG_SIZE_X = 3'd2;
    localparam t_reg_addr REG_SIZE_Y = 3'd3;
    localparam t_reg_addr REG_SIZE_Z = 3'd4;
    localparam t_reg_addr REG_THRESH = 3'd5;

    // control that travels with each item through the divider
    typedef struct packed {
        logic             vld;
        logic             sing;
        logic [N_ENT-1:0] neg;
        logic [N_ENT-1:0] ovf;
    } t_div_tag;

endpackage

### design/navier_symbol_inverse_3x3_unit.sv
// channel   direction  handshake                     payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tdata: index_x, index_y, index_z
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata: inv_11..inv_33, tuser: singular
// cfg       in         i_cfg_valid/o_cfg_ready       i_cfg_addr, i_cfg_data
//
// one index enters per cycle while the output is not stalled; each result passes through the
// input register, 5 angle division stages, 6 cordic stages, 11 entry and determinant
// stages, 32 restoring divider stages (one quotient bit each) and the output register.
// reset clears the valid bits and loads the register defaults; no clearing pass.
// a stall of the output freezes the whole pipe in place; s_axis_tready follows it.
module navier_symbol_inverse_3x3_unit
    import nsi_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [23:0]  s_axis_tdata,   // index_x, index_y, index_z
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [191:0] m_axis_tdata,   // inv_11, inv_12, inv_13, inv_22, inv_23, inv_33
    output logic [0:0]   m_axis_tuser,   // singular
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  t_reg_addr    i_cfg_addr,
    input  logic [31:0]  i_cfg_data
);

    localparam int TW    = FRAC_BITS + 3;
    localparam int SW    = FRAC_BITS + 39;
    localparam int NW    = HMAG_W + 2 * FRAC_BITS;
    localparam int C_SH  = 29 - FRAC_BITS;
    localparam int C_RS  = (C_SH > 0) ? C_SH : 0;
    localparam int C_LS  = (C_SH < 0) ? -C_SH : 0;
    localparam int S_RS  = 30 - FRAC_BITS;
    localparam logic signed [35:0] C_HALF = 36'((64'd1 << C_RS) >> 1);
    localparam logic signed [35:0] S_HALF = 36'((64'd1 << S_RS) >> 1);
    localparam logic signed [SW-1:0] HALF_F = SW'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [2*TW-1:0] HALF_P = (2*TW)'(64'd1 << (FRAC_BITS - 1));
    localparam int CLAMP = (MAX_DIM > 511) ? 511 : MAX_DIM;

    // valid bit of each stage
    localparam int V_IN = 0;
    localparam int V_A0 = 1;
    localparam int V_K0 = V_A0 + ANG_STGS;
    localparam int V_T  = V_K0 + CORDIC_STGS;
    localparam int V_E4 = V_T + 4;
    localparam int V_P6 = V_E4 + 6;
    localparam int NV   = V_P6 + 1;

    function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
        logic signed [31:0] res;
        if (!v[SW-1] && (|v[SW-2:31])) begin
            res = 32'sh7FFFFFFF;
        end else if (v[SW-1] && !(&v[SW-2:31])) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    logic w_adv;
    logic w_out_vld;
    logic w_out_sing;
    logic [OUT_W-1:0] w_inv [N_ENT];
    logic [NV-1:0] r_vld;

    // configuration registers
    logic signed [31:0] r_lambda, r_mu;
    logic [SIZE_W-1:0]  r_size [3];
    logic [30:0]        r_thr;
    logic signed [33:0] r_lp2m, r_mlpm;
    logic signed [35:0] r_base;
    logic [DMAG_W-1:0]  r_thr_sh;
    logic [SIZE_W-1:0]  w_n [3];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lambda <= 32'sd65536;
            r_mu     <= 32'sd65536;
            r_size[0] <= 9'd256;
            r_size[1] <= 9'd256;
            r_size[2] <= 9'd256;
            r_thr    <= 31'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_addr)
                REG_LAMBDA: r_lambda  <= i_cfg_data;
                REG_MU:     r_mu      <= i_cfg_data;
                REG_SIZE_X: r_size[0] <= i_cfg_data[SIZE_W-1:0];
                REG_SIZE_Y: r_size[1] <= i_cfg_data[SIZE_W-1:0];
                REG_SIZE_Z: r_size[2] <= i_cfg_data[SIZE_W-1:0];
                REG_THRESH: r_thr     <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // coefficient sums, refreshed every cycle from the registers
    always_ff @(posedge i_clk) begin
        logic signed [35:0] l_e, m_e, t;
        l_e = r_lambda;
        m_e = r_mu;
        t = l_e + (m_e <<< 1);
        r_lp2m <= t[33:0];
        t = -(l_e + m_e);
        r_mlpm <= t[33:0];
        r_base <= -((l_e + (m_e <<< 2)) <<< 1);
        r_thr_sh <= DMAG_W'(r_thr) << (2 * FRAC_BITS);
    end

    // grid size clamp to 1..256: zero taken as one
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (r_size[a] == '0) begin
                w_n[a] = SIZE_W'(1);
            end else if (r_size[a] > SIZE_W'(CLAMP)) begin
                w_n[a] = SIZE_W'(CLAMP);
            end else begin
                w_n[a] = r_size[a];
            end
        end
    end

    // pipeline advance and valid chain
    assign w_adv         = !w_out_vld || m_axis_tready;
    assign s_axis_tready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NV-2:0], s_axis_tvalid};
        end
    end

    // input register
    logic [IDX_W-1:0] r_idx [3];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_idx[0] <= s_axis_tdata[7:0];
            r_idx[1] <= s_axis_tdata[15:8];
            r_idx[2] <= s_axis_tdata[23:16];
        end
    end

    // phase = low word of floor(index * 2^32 / size), eight quotient bits a stage
    logic [SIZE_W-1:0]  r_ar [ANG_STGS][3];
    logic [PHASE_W-1:0] r_aq [ANG_STGS][3];

    for (genvar s = 0; s < ANG_STGS; s++) begin : g_ang
        logic [SIZE_W-1:0]      w_pr [3];
        logic [PHASE_W-1:0]     w_pq [3];
        logic [ANG_PER_STG-1:0] w_bits [3];
        logic [SIZE_W-1:0]      w_nr [3];
        logic [PHASE_W-1:0]     w_nq [3];

        if (s == 0) begin : g_first
            always_comb begin
                for (int a = 0; a < 3; a++) begin
                    w_pr[a]   = '0;
                    w_pq[a]   = '0;
                    w_bits[a] = r_idx[a];
                end
            end
        end else begin : g_next
            always_comb begin
                for (int a = 0; a < 3; a++) begin
                    w_pr[a]   = r_ar[s-1][a];
                    w_pq[a]   = r_aq[s-1][a];
                    w_bits[a] = '0;
                end
            end
        end

        always_comb begin
            logic [SIZE_W:0]    rs;
            logic [SIZE_W-1:0]  r;
            logic [PHASE_W-1:0] q;
            for (int a = 0; a < 3; a++) begin
                r = w_pr[a];
                q = w_pq[a];
                for (int j = 0; j < ANG_PER_STG; j++) begin
                    rs = {r, w_bits[a][ANG_PER_STG-1-j]};
                    if (rs >= {1'b0, w_n[a]}) begin
                        rs = rs - {1'b0, w_n[a]};
                        q  = {q[PHASE_W-2:0], 1'b1};
                    end else begin
                        q  = {q[PHASE_W-2:0], 1'b0};
                    end
                    r = rs[SIZE_W-1:0];
                end
                w_nr[a] = r;
                w_nq[a] = q;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                for (int a = 0; a < 3; a++) begin
                    r_ar[s][a] <= w_nr[a];
                    r_aq[s][a] <= w_nq[a];
                end
            end
        end
    end

    // cordic rotation on the residual within the quadrant, four steps a stage
    logic signed [CXW-1:0] r_kx [CORDIC_STGS][3];
    logic signed [CXW-1:0] r_ky [CORDIC_STGS][3];
    logic signed [CZW-1:0] r_kz [CORDIC_STGS][3];
    logic [1:0]            r_kq [CORDIC_STGS][3];

    for (genvar s = 0; s < CORDIC_STGS; s++) begin : g_cor
        logic signed [CXW-1:0] w_px [3];
        logic signed [CXW-1:0] w_py [3];
        logic signed [CZW-1:0] w_pz [3];
        logic [1:0]            w_pq [3];
        logic signed [CXW-1:0] w_nx [3];
        logic signed [CXW-1:0] w_ny [3];
        logic signed [CZW-1:0] w_nz [3];

        if (s == 0) begin : g_first
            always_comb begin
                for (int a = 0; a < 3; a++) begin
                    w_px[a] = CORDIC_X0;
                    w_py[a] = '0;
                    w_pz[a] = $signed({3'b000, r_aq[ANG_STGS-1][a][29:0]});
                    w_pq[a] = r_aq[ANG_STGS-1][a][31:30];
                end
            end
        end else begin : g_next
            always_comb begin
                for (int a = 0; a < 3; a++) begin
                    w_px[a] = r_kx[s-1][a];
                    w_py[a] = r_ky[s-1][a];
                    w_pz[a] = r_kz[s-1][a];
                    w_pq[a] = r_kq[s-1][a];
                end
            end
        end

        always_comb begin
            logic signed [CXW-1:0] x, y, xn;
            logic signed [CZW-1:0] z;
            for (int a = 0; a < 3; a++) begin
                x = w_px[a];
                y = w_py[a];
                z = w_pz[a];
                for (int j = 0; j < CORDIC_PER_STG; j++) begin
                    if (!z[CZW-1]) begin
                        xn = x - (y >>> (s * CORDIC_PER_STG + j));
                        y  = y + (x >>> (s * CORDIC_PER_STG + j));
                        z  = z - $signed({1'b0, ATAN_TURN[s * CORDIC_PER_STG + j]});
                    end else begin
                        xn = x + (y >>> (s * CORDIC_PER_STG + j));
                        y  = y - (x >>> (s * CORDIC_PER_STG + j));
                        z  = z + $signed({1'b0, ATAN_TURN[s * CORDIC_PER_STG + j]});
                    end
                    x = xn;
                end
                w_nx[a] = x;
                w_ny[a] = y;
                w_nz[a] = z;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                for (int a = 0; a < 3; a++) begin
                    r_kx[s][a] <= w_nx[a];
                    r_ky[s][a] <= w_ny[a];
                    r_kz[s][a] <= w_nz[a];
                    r_kq[s][a] <= w_pq[a];
                end
            end
        end
    end

    // quadrant map and rounding to 2cos and sin
    logic signed [TW-1:0] r_c2 [3];
    logic signed [TW-1:0] r_sn [3];

    always_ff @(posedge i_clk) begin
        logic signed [35:0] c, sv, cf, sf;
        logic signed [CXW-1:0] x, y;
        if (w_adv) begin
            for (int a = 0; a < 3; a++) begin
                x = r_kx[CORDIC_STGS-1][a];
                y = r_ky[CORDIC_STGS-1][a];
                unique case (r_kq[CORDIC_STGS-1][a])
                    QUAD_0: begin c = x;  sv = y;  end
                    QUAD_1: begin c = y;  c = -c; sv = x; end
                    QUAD_2: begin c = x;  c = -c; sv = y; sv = -sv; end
                    QUAD_3: begin c = y;  sv = x; sv = -sv; end
                    default: begin c = x; sv = y; end
                endcase
                cf = ((c + C_HALF) >>> C_RS) <<< C_LS;
                sf = (sv + S_HALF) >>> S_RS;
                r_c2[a] <= cf[TW-1:0];
                r_sn[a] <= sf[TW-1:0];
            end
        end
    end

    // symbol entries: products
    logic signed [TW+33:0]   r_pl [3];
    logic signed [TW+33:0]   r_pm [3];
    logic signed [2*TW-1:0]  r_ps [3];

    always_ff @(posedge i_clk) begin
        logic signed [TW:0] cs;
        if (w_adv) begin
            for (int e = 0; e < 3; e++) begin
                r_pl[e] <= r_lp2m * r_c2[e];
                cs = (e == 0) ? (r_c2[1] + r_c2[2]) :
                     (e == 1) ? (r_c2[0] + r_c2[2]) : (r_c2[0] + r_c2[1]);
                r_pm[e] <= r_mu * cs;
            end
            r_ps[0] <= r_sn[0] * r_sn[1];
            r_ps[1] <= r_sn[0] * r_sn[2];
            r_ps[2] <= r_sn[1] * r_sn[2];
        end
    end

    // diagonal sums rounded and saturated, sine products rounded
    logic signed [31:0]   r_dg2 [3];
    logic signed [TW-1:0] r_p   [3];

    always_ff @(posedge i_clk) begin
        logic signed [SW-1:0]   acc, b;
        logic signed [2*TW-1:0] pr;
        if (w_adv) begin
            for (int e = 0; e < 3; e++) begin
                b   = r_base;
                b   = b <<< FRAC_BITS;
                acc = b + r_pl[e] + r_pm[e];
                acc = (acc + HALF_F) >>> FRAC_BITS;
                r_dg2[e] <= sat32(acc);
                pr = (r_ps[e] + HALF_P) >>> FRAC_BITS;
                r_p[e] <= pr[TW-1:0];
            end
        end
    end

    // off-diagonal coefficient product
    logic signed [31:0]   r_dg3 [3];
    logic signed [SW-1:0] r_po  [3];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int e = 0; e < 3; e++) begin
                r_dg3[e] <= r_dg2[e];
                r_po[e]  <= r_mlpm * r_p[e];
            end
        end
    end

    // entries d11 d22 d33 and d12 d13 d23
    logic signed [31:0] r_dg [3];
    logic signed [31:0] r_do [3];

    always_ff @(posedge i_clk) begin
        logic signed [SW-1:0] acc;
        if (w_adv) begin
            for (int e = 0; e < 3; e++) begin
                r_dg[e] <= r_dg3[e];
                acc = (r_po[e] + HALF_F) >>> FRAC_BITS;
                r_do[e] <= sat32(acc);
            end
        end
    end

    // pair products for the cofactors
    logic signed [63:0] r_pr [12];
    logic signed [31:0] r_row1a [3];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pr[0]  <= r_dg[1] * r_dg[2];
            r_pr[1]  <= r_do[2] * r_do[2];
            r_pr[2]  <= r_do[1] * r_do[2];
            r_pr[3]  <= r_do[0] * r_dg[2];
            r_pr[4]  <= r_do[0] * r_do[2];
            r_pr[5]  <= r_do[1] * r_dg[1];
            r_pr[6]  <= r_dg[0] * r_dg[2];
            r_pr[7]  <= r_do[1] * r_do[1];
            r_pr[8]  <= r_do[0] * r_do[1];
            r_pr[9]  <= r_dg[0] * r_do[2];
            r_pr[10] <= r_dg[0] * r_dg[1];
            r_pr[11] <= r_do[0] * r_do[0];
            r_row1a[0] <= r_dg[0];
            r_row1a[1] <= r_do[0];
            r_row1a[2] <= r_do[1];
        end
    end

    // cofactors
    logic signed [64:0] r_h2 [N_ENT];
    logic signed [31:0] r_row1b [3];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int e = 0; e < N_ENT; e++) begin
                r_h2[e] <= r_pr[2*e] - r_pr[2*e+1];
            end
            r_row1b <= r_row1a;
        end
    end

    // determinant by first-row expansion, partial products of 32 and 33 bits
    logic signed [64:0] r_dl [3];
    logic signed [64:0] r_dh [3];
    logic signed [64:0] r_h3 [N_ENT];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_dl[i] <= r_row1b[i] * $signed({1'b0, r_h2[i][31:0]});
                r_dh[i] <= r_row1b[i] * $signed(r_h2[i][64:32]);
            end
            r_h3 <= r_h2;
        end
    end

    logic signed [98:0] r_det;
    logic signed [64:0] r_h4 [N_ENT];

    always_ff @(posedge i_clk) begin
        logic signed [98:0] sum, t;
        if (w_adv) begin
            sum = '0;
            for (int i = 0; i < 3; i++) begin
                t   = r_dh[i];
                sum = sum + (t <<< 32);
                t   = r_dl[i];
                sum = sum + t;
            end
            r_det <= sum;
            r_h4  <= r_h3;
        end
    end

    // magnitudes and signs
    logic [DMAG_W-1:0] r_dmag;
    logic              r_dneg;
    logic [HMAG_W-1:0] r_hmag [N_ENT];
    logic [N_ENT-1:0]  r_hneg;

    always_ff @(posedge i_clk) begin
        logic signed [98:0] ad;
        logic signed [64:0] ah;
        if (w_adv) begin
            ad = r_det[98] ? -r_det : r_det;
            r_dmag <= ad[DMAG_W-1:0];
            r_dneg <= r_det[98];
            for (int e = 0; e < N_ENT; e++) begin
                ah = r_h4[e][64] ? -r_h4[e] : r_h4[e];
                r_hmag[e] <= ah[HMAG_W-1:0];
                r_hneg[e] <= r_h4[e][64];
            end
        end
    end

    // singular test and divider set-up
    logic [DMAG_W-1:0] r_dm0;
    logic              r_sing0;
    logic [N_ENT-1:0]  r_neg0;
    logic [N_ENT-1:0]  r_ovf0;
    logic [DMAG_W-1:0] r_rem0 [N_ENT];
    logic [OUT_W-1:0]  r_lo0  [N_ENT];

    always_ff @(posedge i_clk) begin
        logic [NW-1:0]     num;
        logic [DMAG_W-1:0] r0;
        if (w_adv) begin
            r_dm0   <= r_dmag;
            r_sing0 <= (r_dmag == '0) || (r_dmag < r_thr_sh);
            for (int e = 0; e < N_ENT; e++) begin
                num = {r_hmag[e], {(2*FRAC_BITS){1'b0}}};
                r0  = DMAG_W'(num[NW-1:OUT_W]);
                r_neg0[e] <= r_hneg[e] ^ r_dneg;
                r_ovf0[e] <= (r0 >= r_dmag);
                r_rem0[e] <= r0;
                r_lo0[e]  <= num[OUT_W-1:0];
            end
        end
    end

    t_div_tag w_tag;
    always_comb begin
        w_tag.vld  = r_vld[V_P6];
        w_tag.sing = r_sing0;
        w_tag.neg  = r_neg0;
        w_tag.ovf  = r_ovf0;
    end

    nsi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_tag   (w_tag),
        .i_dmag  (r_dm0),
        .i_rem   (r_rem0),
        .i_lo    (r_lo0),
        .o_vld   (w_out_vld),
        .o_sing  (w_out_sing),
        .o_inv   (w_inv)
    );

    // result transaction
    assign m_axis_tvalid   = w_out_vld;
    assign m_axis_tdata    = {w_inv[5], w_inv[4], w_inv[3], w_inv[2], w_inv[1], w_inv[0]};
    assign m_axis_tuser[0] = w_out_sing;

    // a singular result carries all-zero entries
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("singular result with nonzero entries");

    // a stall freezes the valid chain
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld))
        else $error("valid chain moved during stall");

    // a non-singular item never enters the divider with a zero divisor
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[V_P6] && !r_sing0 |-> r_dm0 != '0)
        else $error("zero determinant passed as regular");

    // input register valid feeds the angle stage in order
    a_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_vld[V_IN] |=> r_vld[V_A0])
        else $error("item lost between input and angle stage");

endmodule

### design/nsi_div.sv
module nsi_div
    import nsi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  t_div_tag          i_tag,
    input  logic [DMAG_W-1:0] i_dmag,
    input  logic [DMAG_W-1:0] i_rem [N_ENT],
    input  logic [OUT_W-1:0]  i_lo  [N_ENT],
    output logic              o_vld,
    output logic              o_sing,
    output logic [OUT_W-1:0]  o_inv [N_ENT]
);

    t_div_tag          r_tag [DIV_STEPS];
    logic [DMAG_W-1:0] r_dm  [DIV_STEPS];
    logic [DMAG_W-1:0] r_rem [DIV_STEPS][N_ENT];
    logic [OUT_W-1:0]  r_q   [DIV_STEPS][N_ENT];

    logic              r_vld;
    logic              r_sing;
    logic [OUT_W-1:0]  r_inv [N_ENT];
    logic [OUT_W-1:0]  n_inv [N_ENT];

    // one restoring step per stage, six quotients side by side
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_stage
        t_div_tag          w_ptag;
        logic [DMAG_W-1:0] w_pdm;
        logic [DMAG_W-1:0] w_prem [N_ENT];
        logic [OUT_W-1:0]  w_pq   [N_ENT];
        logic [DMAG_W-1:0] w_nrem [N_ENT];
        logic [OUT_W-1:0]  w_nq   [N_ENT];

        if (k == 0) begin : g_first
            always_comb begin
                w_ptag = i_tag;
                w_pdm  = i_dmag;
                for (int e = 0; e < N_ENT; e++) begin
                    w_prem[e] = i_rem[e];
                    w_pq[e]   = i_lo[e];
                end
            end
        end else begin : g_next
            always_comb begin
                w_ptag = r_tag[k-1];
                w_pdm  = r_dm[k-1];
                for (int e = 0; e < N_ENT; e++) begin
                    w_prem[e] = r_rem[k-1][e];
                    w_pq[e]   = r_q[k-1][e];
                end
            end
        end

        // shift in the next dividend bit, subtract when it fits
        always_comb begin
            logic [DMAG_W:0]   sh;
            logic [DMAG_W+1:0] diff;
            for (int e = 0; e < N_ENT; e++) begin
                sh   = {w_prem[e], w_pq[e][OUT_W-1]};
                diff = {1'b0, sh} - {2'b00, w_pdm};
                if (!diff[DMAG_W+1]) begin
                    w_nrem[e] = diff[DMAG_W-1:0];
                    w_nq[e]   = {w_pq[e][OUT_W-2:0], 1'b1};
                end else begin
                    w_nrem[e] = sh[DMAG_W-1:0];
                    w_nq[e]   = {w_pq[e][OUT_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[k] <= '0;
            end else if (i_en) begin
                r_tag[k] <= w_ptag;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dm[k] <= w_pdm;
                for (int e = 0; e < N_ENT; e++) begin
                    r_rem[k][e] <= w_nrem[e];
                    r_q[k][e]   <= w_nq[e];
                end
            end
        end
    end

    // sign, saturation and zeroing of singular items
    always_comb begin
        t_div_tag         tg;
        logic [OUT_W-1:0] q;
        tg = r_tag[DIV_STEPS-1];
        for (int e = 0; e < N_ENT; e++) begin
            q = r_q[DIV_STEPS-1][e];
            if (tg.sing) begin
                n_inv[e] = '0;
            end else if (!tg.neg[e]) begin
                n_inv[e] = (tg.ovf[e] || q[OUT_W-1]) ? {1'b0, {(OUT_W-1){1'b1}}} : q;
            end else begin
                n_inv[e] = (tg.ovf[e] || (q > {1'b1, {(OUT_W-1){1'b0}}}))
                         ? {1'b1, {(OUT_W-1){1'b0}}} : (~q + 1'b1);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= r_tag[DIV_STEPS-1].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sing <= r_tag[DIV_STEPS-1].sing;
            for (int e = 0; e < N_ENT; e++) begin
                r_inv[e] <= n_inv[e];
            end
        end
    end

    assign o_vld  = r_vld;
    assign o_sing = r_sing;
    assign o_inv  = r_inv;

endmodule
